### rtl/grc_pkg.sv
package grc_pkg;

    localparam int GRID_COLS_DEF = 64;
    localparam int GRID_ROWS_DEF = 64;
    localparam int MAX_STEPS_DEF = 64;
    localparam int TEX_SIZE_DEF  = 64;

    // shared divider: 48-bit dividend, 32-bit divisor
    localparam int DIV_W = 48;
    localparam int DVS_W = 32;

    localparam logic [50:0] SIDE_INF = {1'b1, 50'd0};

    localparam logic REQ_CAST  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [2:0] REG_CAM_POS_X   = 3'd0;
    localparam logic [2:0] REG_CAM_POS_Y   = 3'd1;
    localparam logic [2:0] REG_VIEW_DIR_X  = 3'd2;
    localparam logic [2:0] REG_VIEW_DIR_Y  = 3'd3;
    localparam logic [2:0] REG_CAM_PLANE_X = 3'd4;
    localparam logic [2:0] REG_CAM_PLANE_Y = 3'd5;
    localparam logic [2:0] REG_SCREEN_W    = 3'd6;
    localparam logic [2:0] REG_SCREEN_H    = 3'd7;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic [DIV_W-1:0] quo;
        logic             rem_nz;
    } div_rsp_t;

endpackage

### rtl/grc_ram.sv
module grc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/grc_div.sv
module grc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  grc_pkg::div_req_t req,
    output grc_pkg::div_rsp_t rsp
);
    import grc_pkg::*;

    localparam int CW = $clog2(DIV_W + 1);

    logic             busy_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DIV_W-1:0] q_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0] shifted;
    logic [DVS_W:0] trial;

    // restoring division, one quotient bit per cycle
    assign shifted = {rem_reg, q_reg[DIV_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(DIV_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg   <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DVS_W])
            begin
                rem_reg <= trial[DVS_W-1:0];
                q_reg   <= {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DVS_W-1:0];
                q_reg   <= {q_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.busy   = busy_reg;
    assign rsp.quo    = q_reg;
    assign rsp.rem_nz = |rem_reg;

endmodule

### rtl/grid_ray_caster_column_core.sv
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | req_type column cell_x cell_y cell_value
// out     | output    | out_valid / out_ready| wall_hit .. tex_column
// cfg     | input     | APB psel/penable     | camera and screen registers
//
// A cast item makes six passes through the one radix-2 divider (48 iterations
// each) plus five products on the shared multiplier, and each grid step of the
// walk passes through S_STEP, S_RD and S_CHK for the map read. After reset a
// clearing pass writes GRID_COLS*GRID_ROWS zeros before in_ready rises. A
// finished result sits in the output register; the block takes the next item
// meanwhile and holds its next result until the output is free.
module grid_ray_caster_column_core #(
    parameter int GRID_COLS = grc_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS = grc_pkg::GRID_ROWS_DEF,
    parameter int MAX_STEPS = grc_pkg::MAX_STEPS_DEF,
    parameter int TEX_SIZE  = grc_pkg::TEX_SIZE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic [9:0]         column,
    input  logic [5:0]         cell_x,
    input  logic [5:0]         cell_y,
    input  logic signed [7:0]  cell_value,

    output logic               out_valid,
    input  logic               out_ready,
    output logic               wall_hit,
    output logic               hit_side,
    output logic signed [8:0]  hit_cell_x,
    output logic signed [8:0]  hit_cell_y,
    output logic signed [7:0]  hit_code,
    output logic [15:0]        perp_distance,
    output logic [15:0]        wall_height,
    output logic [9:0]         draw_start,
    output logic [9:0]         draw_end,
    output logic [5:0]         tex_column
);
    import grc_pkg::*;

    localparam int DEPTH = GRID_COLS * GRID_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(MAX_STEPS + 1);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_CAMX, S_CAMXW, S_MRX, S_MRY, S_RY,
        S_DXS, S_DXW, S_DYS, S_DYW, S_SX, S_SY, S_SYW,
        S_STEP, S_RD, S_CHK, S_NUM, S_DSTS, S_DSTW,
        S_WMUL, S_WDS, S_WDW, S_LHS, S_LHW, S_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [15:0]        cam_pos_x_reg, cam_pos_y_reg;
    logic signed [15:0] view_dir_x_reg, view_dir_y_reg;
    logic signed [15:0] cam_plane_x_reg, cam_plane_y_reg;
    logic [10:0]        screen_width_reg, screen_height_reg;

    // datapath
    logic [AW-1:0]      clr_reg;
    logic               is_write_reg;
    logic [9:0]         col_reg;
    logic signed [26:0] camx_reg;
    logic signed [28:0] rdx_reg, rdy_reg;
    logic [30:0]        dx_reg, dy_reg;
    logic [50:0]        sx_reg, sy_reg;
    logic signed [8:0]  mx_reg, my_reg;
    logic [NW-1:0]      n_reg;
    logic               side_reg;
    logic               hit_reg;
    logic signed [7:0]  code_reg;
    logic signed [19:0] num_reg;
    logic [15:0]        dist_reg;
    logic               prod_neg_reg;
    logic [9:0]         frac_reg;
    logic [15:0]        lh_reg;
    logic signed [63:0] prod_reg;

    logic               out_valid_reg;
    logic               wall_hit_reg, hit_side_reg;
    logic signed [8:0]  hit_cell_x_reg, hit_cell_y_reg;
    logic signed [7:0]  hit_code_reg;
    logic [15:0]        perp_distance_reg, wall_height_reg;
    logic [9:0]         draw_start_reg, draw_end_reg;
    logic [5:0]         tex_column_reg;

    logic signed [31:0] mul_a, mul_b;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [7:0]         ram_wdata, ram_rdata;

    logic               cfg_wr;
    logic [10:0]        w_eff;
    logic [28:0]        abs_rdx, abs_rdy;
    logic [10:0]        fx, fy;
    logic signed [28:0] rd_sel, ord_sel;
    logic [15:0]        other;
    logic [28:0]        abs_rd;
    logic [19:0]        abs_num;
    logic [63:0]        abs_prod;
    logic [16:0]        walk_lin, wr_lin;
    logic               walk_in_map, wr_in_map;
    logic signed [7:0]  walk_code;
    logic [9:0]         q_low;
    logic               wall_neg;
    logic signed [16:0] ds_s;
    logic [16:0]        de_u;
    logic [9:0]         ds_v, de_v;
    logic [10:0]        h_m1;
    logic [20:0]        tprod;
    logic [10:0]        tx, tx_m;
    logic               mirror;
    logic               out_free;

    grc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    grc_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_pos_x_reg     <= 16'd22528;
            cam_pos_y_reg     <= 16'd22528;
            view_dir_x_reg    <= 16'sd16384;
            view_dir_y_reg    <= 16'sd0;
            cam_plane_x_reg   <= 16'sd0;
            cam_plane_y_reg   <= 16'sd9459;
            screen_width_reg  <= 11'd320;
            screen_height_reg <= 11'd240;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_CAM_POS_X:   cam_pos_x_reg     <= pwdata[15:0];
                REG_CAM_POS_Y:   cam_pos_y_reg     <= pwdata[15:0];
                REG_VIEW_DIR_X:  view_dir_x_reg    <= $signed(pwdata[15:0]);
                REG_VIEW_DIR_Y:  view_dir_y_reg    <= $signed(pwdata[15:0]);
                REG_CAM_PLANE_X: cam_plane_x_reg   <= $signed(pwdata[15:0]);
                REG_CAM_PLANE_Y: cam_plane_y_reg   <= $signed(pwdata[15:0]);
                REG_SCREEN_W:    screen_width_reg  <= pwdata[10:0];
                REG_SCREEN_H:    screen_height_reg <= pwdata[10:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_CAM_POS_X:   prdata = {16'd0, cam_pos_x_reg};
            REG_CAM_POS_Y:   prdata = {16'd0, cam_pos_y_reg};
            REG_VIEW_DIR_X:  prdata = {16'd0, view_dir_x_reg};
            REG_VIEW_DIR_Y:  prdata = {16'd0, view_dir_y_reg};
            REG_CAM_PLANE_X: prdata = {16'd0, cam_plane_x_reg};
            REG_CAM_PLANE_Y: prdata = {16'd0, cam_plane_y_reg};
            REG_SCREEN_W:    prdata = {21'd0, screen_width_reg};
            REG_SCREEN_H:    prdata = {21'd0, screen_height_reg};
        endcase
    end

    // ---------------- combinational helpers ----------------
    assign w_eff   = (screen_width_reg == 11'd0) ? 11'd1 : screen_width_reg;
    assign abs_rdx = rdx_reg[28] ? 29'(-rdx_reg) : 29'(rdx_reg);
    assign abs_rdy = rdy_reg[28] ? 29'(-rdy_reg) : 29'(rdy_reg);
    assign fx = rdx_reg[28] ? {1'b0, cam_pos_x_reg[9:0]} : 11'd1024 - {1'b0, cam_pos_x_reg[9:0]};
    assign fy = rdy_reg[28] ? {1'b0, cam_pos_y_reg[9:0]} : 11'd1024 - {1'b0, cam_pos_y_reg[9:0]};

    assign rd_sel  = side_reg ? rdy_reg : rdx_reg;
    assign ord_sel = side_reg ? rdx_reg : rdy_reg;
    assign other   = side_reg ? cam_pos_x_reg : cam_pos_y_reg;
    assign abs_rd  = side_reg ? abs_rdy : abs_rdx;
    assign abs_num = num_reg[19] ? 20'(-num_reg) : 20'(num_reg);
    assign abs_prod = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);

    assign walk_lin = 17'(my_reg[7:0]) * 17'(GRID_COLS) + 17'(mx_reg[7:0]);
    assign wr_lin   = 17'(cell_y) * 17'(GRID_COLS) + 17'(cell_x);
    assign walk_in_map = !mx_reg[8] && !my_reg[8]
                      && ({2'b0, mx_reg[7:0]} < 10'(GRID_COLS))
                      && ({2'b0, my_reg[7:0]} < 10'(GRID_ROWS));
    assign wr_in_map = ({4'b0, cell_x} < 10'(GRID_COLS))
                    && ({4'b0, cell_y} < 10'(GRID_ROWS));
    assign walk_code = walk_in_map ? $signed(ram_rdata) : -8'sd1;

    // floor of the signed quotient, low 10 bits only
    assign wall_neg = prod_neg_reg ^ rd_sel[28];
    assign q_low = !wall_neg ? div_rsp.quo[9:0]
                 : (div_rsp.rem_nz ? ~div_rsp.quo[9:0] : 10'(~div_rsp.quo[9:0] + 10'd1));

    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = 8'd0;
        ram_addr  = walk_lin[AW-1:0];
        if (state_reg == S_CLR)
        begin
            ram_we   = 1'b1;
            ram_addr = clr_reg;
        end
        else if (state_reg == S_IDLE)
        begin
            ram_addr  = wr_lin[AW-1:0];
            ram_wdata = cell_value;
            ram_we    = in_valid && (req_type == REQ_WRITE) && wr_in_map;
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MRX:
            begin
                mul_a = 32'(cam_plane_x_reg);
                mul_b = 32'(camx_reg);
            end
            S_MRY:
            begin
                mul_a = 32'(cam_plane_y_reg);
                mul_b = 32'(camx_reg);
            end
            S_SX:
            begin
                mul_a = {21'd0, fx};
                mul_b = {1'b0, dx_reg};
            end
            S_SY:
            begin
                mul_a = {21'd0, fy};
                mul_b = {1'b0, dy_reg};
            end
            S_WMUL:
            begin
                mul_a = 32'(num_reg);
                mul_b = 32'(ord_sel);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            S_CAMX:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'({col_reg, 15'd0});
                div_req.divisor  = DVS_W'(w_eff);
            end
            S_DXS:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(1) << 30;
                div_req.divisor  = DVS_W'(abs_rdx);
            end
            S_DYS:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(1) << 30;
                div_req.divisor  = DVS_W'(abs_rdy);
            end
            S_DSTS:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'({abs_num, 12'd0});
                div_req.divisor  = DVS_W'(abs_rd);
            end
            S_WDS:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = abs_prod[DIV_W-1:0];
                div_req.divisor  = DVS_W'(abs_rd);
            end
            S_LHS:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'({screen_height_reg, 8'd0});
                div_req.divisor  = DVS_W'(dist_reg);
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // draw span and texture column
    assign ds_s = $signed({7'd0, screen_height_reg[10:1]}) - $signed({2'd0, lh_reg[15:1]});
    assign ds_v = ds_s[16] ? 10'd0 : ((|ds_s[15:10]) ? 10'd1023 : ds_s[9:0]);
    assign de_u = {2'd0, lh_reg[15:1]} + {7'd0, screen_height_reg[10:1]};
    assign h_m1 = screen_height_reg - 11'd1;
    always_comb
    begin
        if (screen_height_reg == 11'd0)
        begin
            de_v = 10'd0;
        end
        else if (de_u >= {6'd0, screen_height_reg})
        begin
            de_v = h_m1[10] ? 10'd1023 : h_m1[9:0];
        end
        else
        begin
            de_v = (|de_u[16:10]) ? 10'd1023 : de_u[9:0];
        end
    end

    assign tprod  = 21'(frac_reg) * 21'(TEX_SIZE);
    assign tx     = tprod[20:10];
    assign tx_m   = 11'(TEX_SIZE - 1) - tx;
    assign mirror = (!side_reg && !rdx_reg[28] && (rdx_reg != '0)) || (side_reg && rdy_reg[28]);

    assign out_free = !out_valid_reg || out_ready;

    // ---------------- sequencer ----------------
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            is_write_reg  <= 1'b0;
            n_reg         <= '0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        col_reg      <= column;
                        is_write_reg <= (req_type == REQ_WRITE);
                        state_reg    <= (req_type == REQ_WRITE) ? S_OUT : S_CAMX;
                    end
                end
                S_CAMX: state_reg <= S_CAMXW;
                S_CAMXW:
                begin
                    if (!div_rsp.busy)
                    begin
                        camx_reg  <= $signed({2'b0, div_rsp.quo[24:0]}) - 27'sd16384;
                        state_reg <= S_MRX;
                    end
                end
                S_MRX: state_reg <= S_MRY;
                S_MRY:
                begin
                    rdx_reg   <= 29'(view_dir_x_reg) + $signed(prod_reg[42:14]);
                    state_reg <= S_RY;
                end
                S_RY:
                begin
                    rdy_reg   <= 29'(view_dir_y_reg) + $signed(prod_reg[42:14]);
                    state_reg <= S_DXS;
                end
                S_DXS: state_reg <= S_DXW;
                S_DXW:
                begin
                    if (!div_rsp.busy)
                    begin
                        dx_reg    <= (rdx_reg == '0) ? 31'd0 : div_rsp.quo[30:0];
                        state_reg <= S_DYS;
                    end
                end
                S_DYS: state_reg <= S_DYW;
                S_DYW:
                begin
                    if (!div_rsp.busy)
                    begin
                        dy_reg    <= (rdy_reg == '0) ? 31'd0 : div_rsp.quo[30:0];
                        state_reg <= S_SX;
                    end
                end
                S_SX: state_reg <= S_SY;
                S_SY:
                begin
                    sx_reg    <= (rdx_reg == '0) ? SIDE_INF : prod_reg[50:0];
                    state_reg <= S_SYW;
                end
                S_SYW:
                begin
                    sy_reg    <= (rdy_reg == '0) ? SIDE_INF : prod_reg[50:0];
                    mx_reg    <= $signed({3'b0, cam_pos_x_reg[15:10]});
                    my_reg    <= $signed({3'b0, cam_pos_y_reg[15:10]});
                    n_reg     <= '0;
                    side_reg  <= 1'b1;
                    hit_reg   <= 1'b0;
                    state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    // ties step in y
                    if (sx_reg < sy_reg)
                    begin
                        sx_reg   <= sx_reg + 51'(dx_reg);
                        mx_reg   <= rdx_reg[28] ? mx_reg - 9'sd1 : mx_reg + 9'sd1;
                        side_reg <= 1'b0;
                    end
                    else
                    begin
                        sy_reg   <= sy_reg + 51'(dy_reg);
                        my_reg   <= rdy_reg[28] ? my_reg - 9'sd1 : my_reg + 9'sd1;
                        side_reg <= 1'b1;
                    end
                    state_reg <= S_RD;
                end
                S_RD: state_reg <= S_CHK;
                S_CHK:
                begin
                    code_reg <= walk_code;
                    if (walk_code > 8'sd0)
                    begin
                        hit_reg   <= 1'b1;
                        state_reg <= S_NUM;
                    end
                    else if (n_reg == NW'(MAX_STEPS))
                    begin
                        state_reg <= S_NUM;
                    end
                    else
                    begin
                        n_reg     <= n_reg + 1'b1;
                        state_reg <= S_STEP;
                    end
                end
                S_NUM:
                begin
                    if (!side_reg)
                    begin
                        num_reg <= ($signed(20'(mx_reg)) <<< 10) - $signed({4'd0, cam_pos_x_reg})
                                 + (rdx_reg[28] ? 20'sd1024 : 20'sd0);
                    end
                    else
                    begin
                        num_reg <= ($signed(20'(my_reg)) <<< 10) - $signed({4'd0, cam_pos_y_reg})
                                 + (rdy_reg[28] ? 20'sd1024 : 20'sd0);
                    end
                    state_reg <= S_DSTS;
                end
                S_DSTS: state_reg <= S_DSTW;
                S_DSTW:
                begin
                    if (!div_rsp.busy)
                    begin
                        if (rd_sel == '0)
                        begin
                            dist_reg <= 16'hFFFF;
                        end
                        else if ((num_reg == '0) || (num_reg[19] != rd_sel[28]))
                        begin
                            dist_reg <= 16'd0;
                        end
                        else if (|div_rsp.quo[DIV_W-1:16])
                        begin
                            dist_reg <= 16'hFFFF;
                        end
                        else
                        begin
                            dist_reg <= div_rsp.quo[15:0];
                        end
                        state_reg <= S_WMUL;
                    end
                end
                S_WMUL: state_reg <= S_WDS;
                S_WDS:
                begin
                    prod_neg_reg <= prod_reg[63];
                    state_reg    <= S_WDW;
                end
                S_WDW:
                begin
                    if (!div_rsp.busy)
                    begin
                        frac_reg  <= (rd_sel == '0) ? other[9:0] : other[9:0] + q_low;
                        state_reg <= S_LHS;
                    end
                end
                S_LHS: state_reg <= S_LHW;
                S_LHW:
                begin
                    if (!div_rsp.busy)
                    begin
                        if ((dist_reg == 16'd0) || (|div_rsp.quo[DIV_W-1:16]))
                        begin
                            lh_reg <= 16'hFFFF;
                        end
                        else
                        begin
                            lh_reg <= div_rsp.quo[15:0];
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            if (is_write_reg)
            begin
                wall_hit_reg      <= 1'b0;
                hit_side_reg      <= 1'b0;
                hit_cell_x_reg    <= '0;
                hit_cell_y_reg    <= '0;
                hit_code_reg      <= '0;
                perp_distance_reg <= '0;
                wall_height_reg   <= '0;
                draw_start_reg    <= '0;
                draw_end_reg      <= '0;
                tex_column_reg    <= '0;
            end
            else
            begin
                wall_hit_reg      <= hit_reg;
                hit_side_reg      <= side_reg;
                hit_cell_x_reg    <= mx_reg;
                hit_cell_y_reg    <= my_reg;
                hit_code_reg      <= code_reg;
                perp_distance_reg <= dist_reg;
                wall_height_reg   <= lh_reg;
                draw_start_reg    <= ds_v;
                draw_end_reg      <= de_v;
                tex_column_reg    <= mirror ? tx_m[5:0] : tx[5:0];
            end
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign wall_hit      = wall_hit_reg;
    assign hit_side      = hit_side_reg;
    assign hit_cell_x    = hit_cell_x_reg;
    assign hit_cell_y    = hit_cell_y_reg;
    assign hit_code      = hit_code_reg;
    assign perp_distance = perp_distance_reg;
    assign wall_height   = wall_height_reg;
    assign draw_start    = draw_start_reg;
    assign draw_end      = draw_end_reg;
    assign tex_column    = tex_column_reg;

endmodule

### rtl/grc_checker.sv
module grc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              wall_hit,
    input logic signed [7:0] hit_code,
    input logic [15:0]       perp_distance,
    input logic [15:0]       wall_height
);

    // every accepted item takes the sequencer out of idle, so in_ready is low in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("in_ready high right after an accepted item");

    a_hit_is_wall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && wall_hit) |-> (hit_code > 8'sd0))
        else $error("wall hit reported on a non-wall code");

    a_zero_dist_height: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && wall_hit && perp_distance == 16'd0) |-> (wall_height == 16'hFFFF))
        else $error("zero distance without saturated height");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(perp_distance)))
        else $error("stalled result changed");

endmodule

bind grid_ray_caster_column_core grc_checker u_grc_checker (.*);

### bench/grid_ray_caster_column_core_tb.sv
module grid_ray_caster_column_core_tb;
    import grc_pkg::*;

    localparam int MAP_W = 64;
    localparam int MAP_H = 64;
    localparam int STEP_LIMIT = 64;
    localparam int TEX_W = 64;
    localparam longint SIDE_FAR = 64'd1 << 50;

    typedef struct packed {
        logic              wall_hit;
        logic              hit_side;
        logic [8:0]        hit_cell_x;
        logic [8:0]        hit_cell_y;
        logic [7:0]        hit_code;
        logic [15:0]       perp_distance;
        logic [15:0]       wall_height;
        logic [9:0]        draw_start;
        logic [9:0]        draw_end;
        logic [5:0]        tex_column;
    } column_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               req_type = REQ_CAST;
    logic [9:0]         column = '0;
    logic [5:0]         cell_x = '0;
    logic [5:0]         cell_y = '0;
    logic signed [7:0]  cell_value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               wall_hit;
    logic               hit_side;
    logic signed [8:0]  hit_cell_x;
    logic signed [8:0]  hit_cell_y;
    logic signed [7:0]  hit_code;
    logic [15:0]        perp_distance;
    logic [15:0]        wall_height;
    logic [9:0]         draw_start;
    logic [9:0]         draw_end;
    logic [5:0]         tex_column;

    grid_ray_caster_column_core dut (.*);

    always #6 clk = ~clk;

    // local copy of map and camera registers
    logic signed [7:0] grid_map [MAP_W*MAP_H];
    longint pos_x, pos_y, dir_x, dir_y, plane_x, plane_y, scr_w, scr_h;

    column_result_t pending_columns[$];
    int  err_count = 0;
    int  tx_idle = 0;
    int  rx_idle = 0;
    int  hold_cycles = 0;

    function automatic longint floor_div(longint a, longint b);
        longint q;
        if (b < 0)
        begin
            a = -a;
            b = -b;
        end
        q = a / b;
        if ((a % b) != 0 && a < 0) q = q - 1;
        return q;
    endfunction

    function automatic int map_code(longint x, longint y);
        if (x < 0 || y < 0 || x >= MAP_W || y >= MAP_H) return -1;
        return grid_map[x + y*MAP_W];
    endfunction

    function automatic column_result_t trace_column(longint col);
        column_result_t r;
        longint w, camx, rdx, rdy, mx, my, fx, fy, dx, dy, sx, sy;
        longint num, rd, other, ord, perp, wall, lh, ds, de, tx;
        int stx, sty, side, n;
        bit hit;
        w = (scr_w != 0) ? scr_w : 1;
        camx = floor_div(col * 32768, w) - 16384;
        rdx = dir_x + floor_div(plane_x * camx, 16384);
        rdy = dir_y + floor_div(plane_y * camx, 16384);
        mx = pos_x >>> 10;
        my = pos_y >>> 10;
        stx = rdx < 0 ? -1 : 1;
        sty = rdy < 0 ? -1 : 1;
        fx = rdx < 0 ? (pos_x & 1023) : 1024 - (pos_x & 1023);
        fy = rdy < 0 ? (pos_y & 1023) : 1024 - (pos_y & 1023);
        dx = 0; dy = 0; sx = SIDE_FAR; sy = SIDE_FAR;
        if (rdx != 0)
        begin
            dx = (64'd1 << 30) / (rdx < 0 ? -rdx : rdx);
            sx = fx * dx;
        end
        if (rdy != 0)
        begin
            dy = (64'd1 << 30) / (rdy < 0 ? -rdy : rdy);
            sy = fy * dy;
        end
        hit = 0;
        side = 1;
        for (n = 0; n <= STEP_LIMIT; n++)
        begin
            // ties go to y
            if (sx < sy)
            begin
                sx += dx; mx += stx; side = 0;
            end
            else
            begin
                sy += dy; my += sty; side = 1;
            end
            if (map_code(mx, my) > 0)
            begin
                hit = 1;
                break;
            end
        end
        if (side == 0)
        begin
            num = mx*1024 - pos_x + (stx < 0 ? 1024 : 0);
            rd = rdx; other = pos_y; ord = rdy;
        end
        else
        begin
            num = my*1024 - pos_y + (sty < 0 ? 1024 : 0);
            rd = rdy; other = pos_x; ord = rdx;
        end
        if (rd == 0)
        begin
            perp = 65535;
            wall = other;
        end
        else
        begin
            perp = (num * 4096) / rd;
            if (perp < 0) perp = 0;
            if (perp > 65535) perp = 65535;
            wall = other + floor_div(num * ord, rd);
        end
        lh = (perp == 0) ? 65535 : (scr_h * 256) / perp;
        if (lh > 65535) lh = 65535;
        ds = scr_h/2 - lh/2;
        de = lh/2 + scr_h/2;
        if (ds < 0) ds = 0;
        if (de >= scr_h) de = scr_h - 1;
        if (de < 0) de = 0;
        if (ds > 1023) ds = 1023;
        if (de > 1023) de = 1023;
        tx = ((wall & 1023) * TEX_W) >>> 10;
        if ((side == 0 && rdx > 0) || (side == 1 && rdy < 0)) tx = TEX_W - 1 - tx;
        r.wall_hit = hit;
        r.hit_side = side[0];
        r.hit_cell_x = mx[8:0];
        r.hit_cell_y = my[8:0];
        r.hit_code = 8'(map_code(mx, my));
        r.perp_distance = perp[15:0];
        r.wall_height = lh[15:0];
        r.draw_start = ds[9:0];
        r.draw_end = de[9:0];
        r.tex_column = tx[5:0];
        return r;
    endfunction

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = {idx, 2'b00}; pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_CAM_POS_X:   pos_x = val[15:0];
            REG_CAM_POS_Y:   pos_y = val[15:0];
            REG_VIEW_DIR_X:  dir_x = $signed(val[15:0]);
            REG_VIEW_DIR_Y:  dir_y = $signed(val[15:0]);
            REG_CAM_PLANE_X: plane_x = $signed(val[15:0]);
            REG_CAM_PLANE_Y: plane_y = $signed(val[15:0]);
            REG_SCREEN_W:    scr_w = val[10:0];
            default:         scr_h = val[10:0];
        endcase
    endtask

    task automatic set_camera(int px, int py, int vx, int vy, int cx, int cy, int w, int h);
        reg_write(REG_CAM_POS_X, px);
        reg_write(REG_CAM_POS_Y, py);
        reg_write(REG_VIEW_DIR_X, vx);
        reg_write(REG_VIEW_DIR_Y, vy);
        reg_write(REG_CAM_PLANE_X, cx);
        reg_write(REG_CAM_PLANE_Y, cy);
        reg_write(REG_SCREEN_W, w);
        reg_write(REG_SCREEN_H, h);
    endtask

    task automatic send_item(logic kind, logic [9:0] col, logic [5:0] x, logic [5:0] y,
                             logic [7:0] code);
        column_result_t r;
        @(negedge clk);
        while ($urandom_range(99) < tx_idle)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        req_type = kind; column = col; cell_x = x; cell_y = y; cell_value = code;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (kind == REQ_WRITE)
        begin
            grid_map[x + y*MAP_W] = code;
            r = '0;
        end
        else
        begin
            r = trace_column(col);
        end
        pending_columns.push_back(r);
    endtask

    task automatic cast(logic [9:0] col);
        send_item(REQ_CAST, col, 6'($urandom), 6'($urandom), 8'($urandom));
    endtask

    task automatic put_cell(logic [5:0] x, logic [5:0] y, logic [7:0] code);
        send_item(REQ_WRITE, 10'($urandom), x, y, code);
    endtask

    task automatic drain(int extra);
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_columns.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready = 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else
        begin
            out_ready = ($urandom_range(99) >= rx_idle);
        end
    end

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            err_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        column_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_columns.size() == 0)
            begin
                $error("result with no item pending");
                err_count++;
            end
            else
            begin
                e = pending_columns.pop_front();
                check_field("wall_hit", e.wall_hit, wall_hit);
                check_field("hit_side", e.hit_side, hit_side);
                check_field("hit_cell_x", e.hit_cell_x, hit_cell_x[8:0]);
                check_field("hit_cell_y", e.hit_cell_y, hit_cell_y[8:0]);
                check_field("hit_code", e.hit_code, hit_code[7:0]);
                check_field("perp_distance", e.perp_distance, perp_distance);
                check_field("wall_height", e.wall_height, wall_height);
                check_field("draw_start", e.draw_start, draw_start);
                check_field("draw_end", e.draw_end, draw_end);
                check_field("tex_column", e.tex_column, tex_column);
            end
        end
    end

    task automatic test_directed();
        tx_idle = 20; rx_idle = 20;
        put_cell(0, 0, 8'sd127);
        put_cell(63, 63, 8'h80);
        put_cell(30, 22, 8'sd3);
        put_cell(22, 40, 8'sd1);
        put_cell(63, 0, 8'sd0);
        cast(0);
        cast(160);
        cast(319);
        cast(1023);
        drain(20);
        // wall right next to the camera on a grid line gives zero distance
        set_camera(10*1024, 22528, -16384, 0, 0, 0, 0, 240);
        put_cell(9, 22, 8'sd5);
        cast(0);
        cast(700);
        drain(20);
        // both ray components zero: walk in y only
        set_camera(5*1024 + 300, 5*1024 + 700, 0, 0, 0, 0, 1, 1);
        cast(0);
        cast(1023);
        drain(20);
        // x component zero, crossing y lines
        set_camera(65535, 65535, 0, -16384, 0, 0, 2047, 2047);
        cast(5);
        drain(20);
        set_camera(0, 0, 32767, 32767, -32768, 32767, 1024, 1024);
        cast(0);
        cast(512);
        cast(1023);
        drain(20);
    endtask

    function automatic int pick16(bit signed_reg);
        case ($urandom_range(9))
            0: return signed_reg ? 32'h8000 : 0;
            1: return signed_reg ? 32'h7fff : 32'hffff;
            2: return 0;
            default: return signed_reg ? $urandom_range(65535)
                                       : $urandom_range(63*1024 + 1023, 1024);
        endcase
    endfunction

    task automatic test_random(int n_cfg, int n_items, int sidle, int ridle);
        int k, i;
        for (k = 0; k < n_cfg; k++)
        begin
            drain(20);
            tx_idle = sidle; rx_idle = ridle;
            set_camera(pick16(0), pick16(0), pick16(1), pick16(1), pick16(1), pick16(1),
                       ($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(1024, 1),
                       ($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(1024, 1));
            for (i = 0; i < n_items; i++)
            begin
                if ($urandom_range(99) < 40)
                    put_cell(6'($urandom), 6'($urandom),
                             8'($urandom_range(1) ? $urandom_range(127, 1)
                                                  : $urandom_range(255)));
                else
                    cast(10'($urandom_range(3) == 0 ? $urandom_range(1023)
                                                    : $urandom_range(scr_w)));
            end
        end
    endtask

    task automatic test_backpressure();
        int i;
        drain(20);
        tx_idle = 0; rx_idle = 0;
        hold_cycles = 3000;
        for (i = 0; i < 8; i++)
        begin
            put_cell(6'($urandom), 6'($urandom), 8'($urandom));
            cast(10'($urandom_range(1023)));
        end
    endtask

    initial
    begin
        foreach (grid_map[i]) grid_map[i] = '0;
        pos_x = 22528; pos_y = 22528; dir_x = 16384; dir_y = 0;
        plane_x = 0; plane_y = 9459; scr_w = 320; scr_h = 240;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(5, 110, 38, 61);
        test_random(5, 110, 61, 38);
        test_backpressure();
        test_random(5, 110, 0, 0);
        drain(800);
        if (err_count == 0)
            $display("grid_ray_caster_column_core_tb: done, clean");
        else
            $display("grid_ray_caster_column_core_tb: done, errors");
        $finish;
    end

    initial
    begin
        #(12 * 6000000);
        $display("grid_ray_caster_column_core_tb: done, errors");
        $finish;
    end

endmodule
